/* rtl/time_of_day_arithmetic_macros.svh */
// Assertion macros used by the checker of the time of day block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TIME_OF_DAY_ARITHMETIC_MACROS_SVH
`define TIME_OF_DAY_ARITHMETIC_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tda_pkg.sv */
package tda_pkg;

  // Calendar constants.
  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 60 * 60;
  localparam int SEC_PER_MIN  = 60;
  localparam int HOUR_MAX     = 23;
  localparam int MINSEC_MAX   = 59;

  // 86400 = 675 * 128, so the day wrap splits into a shift and a mod 675.
  localparam int DAY_ODD      = 675;
  localparam int DAY_SHIFT    = 7;

  // Widths of the internal values.
  localparam int TOD_W  = 17;  // seconds of a day, also a raw total up to 115443
  localparam int SUM_W  = 35;  // signed sum of a total and a 32-bit offset, plus bias
  localparam int BIAS_W = 33;  // biased sum is always positive and below 2**33
  localparam int HI_W   = BIAS_W - DAY_SHIFT;  // upper part that is reduced mod 675
  localparam int Q_W    = 17;  // quotient of the upper part by 675
  localparam int REM_W  = 12;  // seconds within an hour
  localparam int DIST_W = 16;

  // Multiple of a day that lifts any sum to a non-negative value.
  localparam logic [31:0] DAY_BIAS = 32'd2147558400;

  // Exact reciprocals: floor(x * RECIP >> SH) equals floor(x / divisor)
  // over the whole range of x that reaches each multiplier.
  localparam logic [27:0] RECIP_ODD     = 28'd203613265;
  localparam int          RECIP_ODD_SH  = 37;
  localparam logic [18:0] RECIP_HOUR    = 19'd298262;
  localparam int          RECIP_HOUR_SH = 30;
  localparam logic [12:0] RECIP_MIN     = 13'd4370;
  localparam int          RECIP_MIN_SH  = 18;

  // Operation codes.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // Number of register stages from input to result.
  localparam int unsigned TDA_STAGES = 7;

endpackage

/* rtl/tda_pipe_ctl.sv */
module tda_pipe_ctl
  import tda_pkg::*;
#(
  parameter int unsigned NSTG = TDA_STAGES
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output logic [NSTG-1:0] load
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] vld_src;
  logic [NSTG:0]   rdy;

  // A stage can load when it is empty or its item moves on this cycle.
  assign rdy[NSTG] = !out_stall;

  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld_r[k] || rdy[k+1];
  end

  // Each stage takes the valid bit of the stage before it.
  assign vld_src = {vld_r[NSTG-2:0], in_valid};
  assign vld_nxt = (rdy[NSTG-1:0] & vld_src) | (~rdy[NSTG-1:0] & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign load      = rdy[NSTG-1:0];
  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

endmodule

/* rtl/time_of_day_arithmetic.sv */
// Channel   Handshake              Payload
// input     in_valid / in_stall    op, time A, offset_seconds, time B
// result    out_valid / out_stall  shifted A (h:m:s), distance, compare flags, invalid
//
// One item is taken every cycle while in_stall is low; seven register stages hold items.
// The stages are the input register, the biased sum with the compare, and one register
// after each reciprocal multiply and each back-subtract (day wrap, hour, minute), where
// the hour back-subtract and the minute multiply share one register.
// Reset clears the stage valid bits only; the payload registers are not reset.
// A stall on the result side holds the last stage; empty stages ahead of it still fill,
// and in_stall rises only when every stage holds an item.
module time_of_day_arithmetic
  import tda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [4:0]  in_hour_a,
  input  logic [5:0]  in_minute_a,
  input  logic [5:0]  in_second_a,
  input  logic signed [31:0] in_offset_seconds,
  input  logic [4:0]  in_hour_b,
  input  logic [5:0]  in_minute_b,
  input  logic [5:0]  in_second_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_new_hour,
  output logic [5:0]  out_new_minute,
  output logic [5:0]  out_new_second,
  output logic [15:0] out_distance,
  output logic        out_a_less,
  output logic        out_a_equal,
  output logic        out_a_greater,
  output logic        out_invalid
);

  typedef struct packed {
    logic        op;
    logic [4:0]  hour_a;
    logic [5:0]  minute_a;
    logic [5:0]  second_a;
    logic [31:0] offset_seconds;
    logic [4:0]  hour_b;
    logic [5:0]  minute_b;
    logic [5:0]  second_b;
  } s0_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              a_less;
    logic              a_equal;
    logic              a_greater;
    logic              invalid;
  } cmp_t;

  typedef struct packed {
    logic [HI_W-1:0]      hi;
    logic [DAY_SHIFT-1:0] lo;
    cmp_t                 cmp;
  } s1_t;

  typedef struct packed {
    logic [Q_W-1:0]       q;
    logic [HI_W-1:0]      hi;
    logic [DAY_SHIFT-1:0] lo;
    cmp_t                 cmp;
  } s2_t;

  typedef struct packed {
    logic [TOD_W-1:0] tod;
    cmp_t             cmp;
  } s3_t;

  typedef struct packed {
    logic [4:0]       hour;
    logic [TOD_W-1:0] tod;
    cmp_t             cmp;
  } s4_t;

  typedef struct packed {
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [REM_W-1:0] rem;
    cmp_t             cmp;
  } s5_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    cmp_t       cmp;
  } s6_t;

  logic [TDA_STAGES-1:0] load;

  s0_t s0_r, s0_nxt;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;

  logic [TOD_W-1:0]  ta, tb, ra, rb, diff, alt, short_dist;
  logic [SUM_W-1:0]  ta_ext, off_ext, sum, biased;
  logic [HI_W+27:0]  prod_odd;
  logic [HI_W-1:0]   odd_rem;
  logic [TOD_W+18:0] prod_hour;
  logic [REM_W-1:0]  rem;
  logic [REM_W+12:0] prod_min;

  // Stage valid bits and load enables.
  tda_pipe_ctl #(
    .NSTG (TDA_STAGES)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .load      (load)
  );

  // Input register.
  always_comb begin
    s0_nxt.op             = in_op;
    s0_nxt.hour_a         = in_hour_a;
    s0_nxt.minute_a       = in_minute_a;
    s0_nxt.second_a       = in_second_a;
    s0_nxt.offset_seconds = in_offset_seconds;
    s0_nxt.hour_b         = in_hour_b;
    s0_nxt.minute_b       = in_minute_b;
    s0_nxt.second_b       = in_second_b;
  end

  // Seconds totals, biased shifted sum, comparison and distance.
  always_comb begin
    ta = TOD_W'(s0_r.hour_a) * TOD_W'(SEC_PER_HOUR)
       + TOD_W'(s0_r.minute_a) * TOD_W'(SEC_PER_MIN) + TOD_W'(s0_r.second_a);
    tb = TOD_W'(s0_r.hour_b) * TOD_W'(SEC_PER_HOUR)
       + TOD_W'(s0_r.minute_b) * TOD_W'(SEC_PER_MIN) + TOD_W'(s0_r.second_b);

    ta_ext  = SUM_W'(ta);
    off_ext = {{(SUM_W-32){s0_r.offset_seconds[31]}}, s0_r.offset_seconds};
    if (s0_r.op == OP_SUB) begin
      sum = ta_ext - off_ext;
    end else begin
      sum = ta_ext + off_ext;
    end
    // The bias is a whole number of days, so the wrap is unchanged.
    biased = sum + SUM_W'(DAY_BIAS);

    s1_nxt.hi = biased[BIAS_W-1:DAY_SHIFT];
    s1_nxt.lo = biased[DAY_SHIFT-1:0];

    // A raw total reaches less than two days, so one subtract wraps it.
    ra = (ta >= TOD_W'(SEC_PER_DAY)) ? ta - TOD_W'(SEC_PER_DAY) : ta;
    rb = (tb >= TOD_W'(SEC_PER_DAY)) ? tb - TOD_W'(SEC_PER_DAY) : tb;
    diff = (ra >= rb) ? ra - rb : rb - ra;
    alt  = TOD_W'(SEC_PER_DAY) - diff;
    short_dist = (alt < diff) ? alt : diff;

    s1_nxt.cmp.distance  = short_dist[DIST_W-1:0];
    s1_nxt.cmp.a_less    = ta < tb;
    s1_nxt.cmp.a_equal   = ta == tb;
    s1_nxt.cmp.a_greater = ta > tb;
    s1_nxt.cmp.invalid   = (s0_r.hour_a > 5'(HOUR_MAX)) || (s0_r.minute_a > 6'(MINSEC_MAX))
                        || (s0_r.second_a > 6'(MINSEC_MAX)) || (s0_r.hour_b > 5'(HOUR_MAX))
                        || (s0_r.minute_b > 6'(MINSEC_MAX)) || (s0_r.second_b > 6'(MINSEC_MAX));
  end

  // Quotient of the upper part by 675.
  always_comb begin
    prod_odd   = (HI_W+28)'(s1_r.hi) * (HI_W+28)'(RECIP_ODD);
    s2_nxt.q   = Q_W'(prod_odd >> RECIP_ODD_SH);
    s2_nxt.hi  = s1_r.hi;
    s2_nxt.lo  = s1_r.lo;
    s2_nxt.cmp = s1_r.cmp;
  end

  // Remainder mod 675 joined with the low bits gives the seconds of the day.
  always_comb begin
    odd_rem    = s2_r.hi - HI_W'(s2_r.q) * HI_W'(DAY_ODD);
    s3_nxt.tod = {odd_rem[TOD_W-DAY_SHIFT-1:0], s2_r.lo};
    s3_nxt.cmp = s2_r.cmp;
  end

  // Hour of the shifted time.
  always_comb begin
    prod_hour   = (TOD_W+19)'(s3_r.tod) * (TOD_W+19)'(RECIP_HOUR);
    s4_nxt.hour = 5'(prod_hour >> RECIP_HOUR_SH);
    s4_nxt.tod  = s3_r.tod;
    s4_nxt.cmp  = s3_r.cmp;
  end

  // Seconds within the hour and the minute.
  always_comb begin
    rem           = REM_W'(s4_r.tod - TOD_W'(s4_r.hour) * TOD_W'(SEC_PER_HOUR));
    prod_min      = (REM_W+13)'(rem) * (REM_W+13)'(RECIP_MIN);
    s5_nxt.hour   = s4_r.hour;
    s5_nxt.minute = 6'(prod_min >> RECIP_MIN_SH);
    s5_nxt.rem    = rem;
    s5_nxt.cmp    = s4_r.cmp;
  end

  // Second within the minute, into the result register.
  always_comb begin
    s6_nxt.hour   = s5_r.hour;
    s6_nxt.minute = s5_r.minute;
    s6_nxt.second = 6'(s5_r.rem - REM_W'(s5_r.minute) * REM_W'(SEC_PER_MIN));
    s6_nxt.cmp    = s5_r.cmp;
  end

  // Payload registers, each loaded when its stage can take an item.
  always_ff @(posedge clk) begin
    if (load[0]) s0_r <= s0_nxt;
    if (load[1]) s1_r <= s1_nxt;
    if (load[2]) s2_r <= s2_nxt;
    if (load[3]) s3_r <= s3_nxt;
    if (load[4]) s4_r <= s4_nxt;
    if (load[5]) s5_r <= s5_nxt;
    if (load[6]) s6_r <= s6_nxt;
  end

  assign out_new_hour   = s6_r.hour;
  assign out_new_minute = s6_r.minute;
  assign out_new_second = s6_r.second;
  assign out_distance   = s6_r.cmp.distance;
  assign out_a_less     = s6_r.cmp.a_less;
  assign out_a_equal    = s6_r.cmp.a_equal;
  assign out_a_greater  = s6_r.cmp.a_greater;
  assign out_invalid    = s6_r.cmp.invalid;

endmodule

/* rtl/tda_checker.sv */
`include "time_of_day_arithmetic_macros.svh"

module tda_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_new_hour,
  input logic [5:0]  out_new_minute,
  input logic [5:0]  out_new_second,
  input logic [15:0] out_distance,
  input logic        out_a_less,
  input logic        out_a_equal,
  input logic        out_a_greater,
  input logic        out_invalid
);

  logic [2:0]  flags;
  logic [36:0] payload;
  logic        in_range;

  assign flags   = {out_a_less, out_a_equal, out_a_greater};
  assign payload = {out_new_hour, out_new_minute, out_new_second, out_distance,
                    flags, out_invalid};

  // The shifted time is always a legal time of day and the distance is half a day at most.
  assign in_range = (out_new_hour <= 5'd23) && (out_new_minute <= 6'd59)
                 && (out_new_second <= 6'd59) && (out_distance <= 16'd43200);

  // A held result keeps its contents until it is taken.
  `TDA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(payload), "result changed while stalled")

  // Exactly one ordering flag is set on every item.
  `TDA_ASSERT_SAME(a_flags, out_valid, $onehot(flags), "ordering flags not one-hot")

  `TDA_ASSERT_SAME(a_range, out_valid, in_range, "result field out of range")

  // Equal times are zero seconds apart.
  `TDA_ASSERT_SAME(a_equal_dist, out_valid && out_a_equal, out_distance == 16'd0, "equal times with nonzero distance")

endmodule

bind time_of_day_arithmetic tda_checker u_tda_checker (.*);
